>>> hw/rtl/bmsort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmsort_pkg;

	// value width, used by the beat formats below
	localparam int VALUE_WIDTH = 32;
	localparam int STORE_DEPTH = 64;

	// merge statistics, saturating
	localparam int TALLY_W = 9;
	localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

	// input beat
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] sample_value;
		logic                          final_item;
	} sample_t;

	// output beat
	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] sorted_value;
		logic                          end_of_run;
		logic [TALLY_W-1:0]            compare_count;
		logic [TALLY_W-1:0]            move_count;
		logic                          overflowed;
	} result_t;

	// source of the store write data
	typedef enum logic [1:0] {
		WR_IN,
		WR_A,
		WR_B
	} wr_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic    wr_en;
		logic    wr_bank;
		wr_sel_t wr_sel;
		logic    rd_bank;
		logic    out_load;
	} dp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/bottom_up_merge_sorter.sv
// bottom_up_merge_sorter: stable ascending sort of a set of signed values.
// sample channel: one value per beat, final_item marks the last value of a
// set. Beats are taken one per cycle while loading; values beyond
// STORE_DEPTH are dropped and the set is flagged as overflowed.
// after the final beat the block merges in place between two store banks:
// ceil(log2 n) passes; each element is read in ST_MRD and written in
// ST_MWR, the two heads coming from the two read ports of a bank, and each
// block starts with a setup step in ST_BLOCK.
// result channel: one beat per value in ascending order, the last marked
// end_of_run and carrying the comparison and move tallies; each result beat
// goes through a store read, an output register load and a handshake.
// sample_ready is low from the final beat until the last
// result beat is taken; a stalled receiver simply holds the output register.
// reset clears the control state and tallies; the stores are not cleared
// and need no sweep, only entries written for the current set are read.
`timescale 1ns / 1ps
`default_nettype none

module bottom_up_merge_sorter #(
	parameter int STORE_DEPTH = bmsort_pkg::STORE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  sample_valid,
	output logic                 sample_ready,
	input  wire bmsort_pkg::sample_t sample,
	output logic                 result_valid,
	input  wire                  result_ready,
	output bmsort_pkg::result_t  result
);

	localparam int IW = $clog2(STORE_DEPTH);

	bmsort_pkg::dp_cmd_t cmd;
	logic [IW-1:0]       wr_addr, rd_addr_a, rd_addr_b;
	logic                a_le_b;

	// sequencer
	bmsort_ctrl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_final (sample.final_item),
		.sample_ready (sample_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.end_of_run   (result.end_of_run),
		.compare_count(result.compare_count),
		.move_count   (result.move_count),
		.overflowed   (result.overflowed),
		.a_le_b       (a_le_b),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b)
	);

	// stores and compare
	bmsort_dp #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_dp (
		.clk          (clk),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.sample_value (sample.sample_value),
		.a_le_b       (a_le_b),
		.sorted_value (result.sorted_value)
	);

	// loading and emission never overlap
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample_ready && result_valid))
		else $error("sample_ready while a result beat is pending");

	// tallies only on the last beat of a set
	a_tally_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.end_of_run |->
			result.compare_count == '0 && result.move_count == '0)
		else $error("tally on a beat that does not end the set");

	// every comparison goes with a move
	a_moves_cover: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.end_of_run |->
			result.move_count >= result.compare_count)
		else $error("fewer moves than comparisons");

	// after the last result beat the block loads again
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && result.end_of_run |=> sample_ready)
		else $error("not ready to load after end of set");

endmodule

`default_nettype wire

>>> hw/rtl/bmsort_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bmsort_dp #(
	parameter int STORE_DEPTH = bmsort_pkg::STORE_DEPTH
) (
	input  wire                                     clk,
	input  wire bmsort_pkg::dp_cmd_t                cmd,
	input  wire [$clog2(STORE_DEPTH)-1:0]           wr_addr,
	input  wire [$clog2(STORE_DEPTH)-1:0]           rd_addr_a,
	input  wire [$clog2(STORE_DEPTH)-1:0]           rd_addr_b,
	input  wire [bmsort_pkg::VALUE_WIDTH-1:0]       sample_value,
	output logic                                    a_le_b,
	output logic [bmsort_pkg::VALUE_WIDTH-1:0]      sorted_value
);

	localparam int VW = bmsort_pkg::VALUE_WIDTH;

	// two banks, ping-pong between merge passes
	logic [VW-1:0] mem0 [STORE_DEPTH];
	logic [VW-1:0] mem1 [STORE_DEPTH];

	logic [VW-1:0] rd0a_q, rd0b_q, rd1a_q, rd1b_q;
	logic [VW-1:0] rda, rdb, wdata;
	logic [VW-1:0] sorted_q;

	// write data select
	always_comb begin
		case (cmd.wr_sel)
			bmsort_pkg::WR_A: wdata = rda;
			bmsort_pkg::WR_B: wdata = rdb;
			default:          wdata = sample_value;
		endcase
	end

	// bank 0: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_en && !cmd.wr_bank) begin
			mem0[wr_addr] <= wdata;
		end
		rd0a_q <= mem0[rd_addr_a];
		rd0b_q <= mem0[rd_addr_b];
	end

	// bank 1
	always_ff @(posedge clk) begin
		if (cmd.wr_en && cmd.wr_bank) begin
			mem1[wr_addr] <= wdata;
		end
		rd1a_q <= mem1[rd_addr_a];
		rd1b_q <= mem1[rd_addr_b];
	end

	// head values of the current source bank
	assign rda = cmd.rd_bank ? rd1a_q : rd0a_q;
	assign rdb = cmd.rd_bank ? rd1b_q : rd0b_q;

	// ties go to the left run
	assign a_le_b = ($signed(rda) <= $signed(rdb));

	// output value register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sorted_q <= rda;
		end
	end

	assign sorted_value = sorted_q;

endmodule

`default_nettype wire

>>> hw/rtl/bmsort_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bmsort_ctrl #(
	parameter int STORE_DEPTH = bmsort_pkg::STORE_DEPTH
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 sample_valid,
	input  wire                                 sample_final,
	output logic                                sample_ready,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output logic                                end_of_run,
	output logic [bmsort_pkg::TALLY_W-1:0]      compare_count,
	output logic [bmsort_pkg::TALLY_W-1:0]      move_count,
	output logic                                overflowed,
	input  wire                                 a_le_b,
	output bmsort_pkg::dp_cmd_t                 cmd,
	output logic [$clog2(STORE_DEPTH)-1:0]      wr_addr,
	output logic [$clog2(STORE_DEPTH)-1:0]      rd_addr_a,
	output logic [$clog2(STORE_DEPTH)-1:0]      rd_addr_b
);

	localparam int IW = $clog2(STORE_DEPTH);
	localparam int CW = IW + 1;
	localparam int NW = IW + 3;
	localparam int TW = bmsort_pkg::TALLY_W;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BLOCK,
		ST_MRD,
		ST_MWR,
		ST_ERD,
		ST_ELD,
		ST_EWAIT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic          dropped_q;
	logic [TW-1:0] cmp_q, mov_q;
	logic [NW-1:0] w_q, s_q, mid_q, hi_q, a_q, b_q, k_q;
	logic          src_q, counted_q;
	logic          valid_q, end_q, ovf_q;
	logic [TW-1:0] cmp_out_q, mov_out_q;

	logic [NW-1:0] last, mid_raw, hi_raw, w_dbl;
	logic [CW-1:0] cnt_nx;
	logic          room, accept, a_ok, b_ok, take_a;

	// block bounds and merge decision
	always_comb begin
		last    = NW'(cnt_q) - 1'b1;
		w_dbl   = w_q << 1;
		mid_raw = s_q + w_q - 1'b1;
		hi_raw  = s_q + w_dbl - 1'b1;
		room    = (cnt_q < CW'(STORE_DEPTH));
		cnt_nx  = room ? cnt_q + 1'b1 : cnt_q;
		accept  = sample_valid && (state_q == ST_LOAD);
		a_ok    = (a_q <= mid_q);
		b_ok    = (b_q <= hi_q);
		take_a  = !b_ok || (a_ok && a_le_b);
	end

	// datapath commands
	always_comb begin
		cmd.wr_en    = (accept && room) || (state_q == ST_MWR);
		cmd.wr_bank  = (state_q == ST_LOAD) ? 1'b0 : !src_q;
		cmd.wr_sel   = (state_q == ST_LOAD) ? bmsort_pkg::WR_IN
			: (take_a ? bmsort_pkg::WR_A : bmsort_pkg::WR_B);
		cmd.rd_bank  = src_q;
		cmd.out_load = (state_q == ST_ELD);
		wr_addr      = (state_q == ST_LOAD) ? cnt_q[IW-1:0] : k_q[IW-1:0];
		rd_addr_a    = a_q[IW-1:0];
		rd_addr_b    = b_q[IW-1:0];
	end

	// sequencer: load, merge passes, emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			cnt_q     <= '0;
			dropped_q <= 1'b0;
			cmp_q     <= '0;
			mov_q     <= '0;
			w_q       <= '0;
			s_q       <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			a_q       <= '0;
			b_q       <= '0;
			k_q       <= '0;
			src_q     <= 1'b0;
			counted_q <= 1'b0;
			valid_q   <= 1'b0;
			end_q     <= 1'b0;
			ovf_q     <= 1'b0;
			cmp_out_q <= '0;
			mov_out_q <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						cnt_q <= cnt_nx;
						if (!room) begin
							dropped_q <= 1'b1;
						end
						if (sample_final) begin
							src_q <= 1'b0;
							a_q   <= '0;
							w_q   <= NW'(1);
							s_q   <= '0;
							if (cnt_nx >= CW'(2)) begin
								state_q <= ST_BLOCK;
							end else begin
								state_q <= ST_ERD;
							end
						end
					end
				end
				ST_BLOCK: begin
					if (s_q >= NW'(cnt_q)) begin
						// pass done, result now in the other bank
						src_q <= !src_q;
						if (w_dbl <= last) begin
							w_q <= w_dbl;
							s_q <= '0;
						end else begin
							a_q     <= '0;
							state_q <= ST_ERD;
						end
					end else begin
						mid_q     <= (mid_raw > last) ? last : mid_raw;
						hi_q      <= (hi_raw > last) ? last : hi_raw;
						a_q       <= s_q;
						b_q       <= ((mid_raw > last) ? last : mid_raw) + 1'b1;
						k_q       <= s_q;
						counted_q <= (s_q < last);
						state_q   <= ST_MRD;
					end
				end
				ST_MRD: begin
					state_q <= ST_MWR;
				end
				ST_MWR: begin
					// one element written per visit
					if (a_ok && b_ok && cmp_q != bmsort_pkg::TALLY_MAX) begin
						cmp_q <= cmp_q + 1'b1;
					end
					if (counted_q && mov_q != bmsort_pkg::TALLY_MAX) begin
						mov_q <= mov_q + 1'b1;
					end
					if (take_a) begin
						a_q <= a_q + 1'b1;
					end else begin
						b_q <= b_q + 1'b1;
					end
					k_q <= k_q + 1'b1;
					if (k_q == hi_q) begin
						s_q     <= s_q + w_dbl;
						state_q <= ST_BLOCK;
					end else begin
						state_q <= ST_MRD;
					end
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					valid_q   <= 1'b1;
					end_q     <= (a_q == last);
					cmp_out_q <= (a_q == last) ? cmp_q : '0;
					mov_out_q <= (a_q == last) ? mov_q : '0;
					ovf_q     <= dropped_q;
					state_q   <= ST_EWAIT;
				end
				ST_EWAIT: begin
					if (result_ready) begin
						valid_q <= 1'b0;
						if (end_q) begin
							cnt_q     <= '0;
							dropped_q <= 1'b0;
							cmp_q     <= '0;
							mov_q     <= '0;
							state_q   <= ST_LOAD;
						end else begin
							a_q     <= a_q + 1'b1;
							state_q <= ST_ERD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign sample_ready  = (state_q == ST_LOAD);
	assign result_valid  = valid_q;
	assign end_of_run    = end_q;
	assign compare_count = cmp_out_q;
	assign move_count    = mov_out_q;
	assign overflowed    = ovf_q;

endmodule

`default_nettype wire
